// ===== design/textured_column_rasterizer_macros.svh =====
// assertion macros shared by the textured column rasterizer modules
`ifndef TEXTURED_COLUMN_RASTERIZER_MACROS_SVH
`define TEXTURED_COLUMN_RASTERIZER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define TCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcr assertion failed: same-cycle implication");
// next-cycle implication, sampled on clk, off while rst_n is low
`define TCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcr assertion failed: next-cycle implication");
`else
`define TCR_ASSERT_IMP(lbl, ante, cons)
`define TCR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/tcr_pkg.sv =====
// shared types and constants of the textured column rasterizer
package tcr_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH = 256;
  localparam int VIEW_HEIGHT  = 64;
  localparam int ROW_W        = 6;
  localparam int COL_W        = 8;
  localparam int ADDR_W       = 16;
  localparam int COLUMN_SHIFT = 2;

  // texture walk: start and step come from bits 22:7
  localparam int WALK_SHIFT   = (8 - 1);
  localparam int TEXEL_SHIFT  = (8 + 1);
  localparam int WALK_W       = 16;
  localparam int PROD_W       = WALK_SHIFT + WALK_W;
  localparam int DIFF_W       = 9;

  // tables
  localparam int CT_DEPTH     = 256;
  localparam int CT_AW        = 8;
  localparam int TEX_DEPTH    = 128;
  localparam int TEX_AW       = WALK_W - TEXEL_SHIFT;
  localparam int DATA_W       = 8;

  // command queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = 1;
  localparam int QUEUE_CW     = 2;

  // configuration
  localparam logic [7:0] CENTER_RESET = 8'd32;

  // stream widths
  localparam int IN_DATA_W    = 104;
  localparam int OUT_DATA_W   = 24;

  typedef enum logic [1:0] {
    MODE_TABLE    = 2'd0,
    MODE_TEXEL    = 2'd1,
    MODE_TEXTURED = 2'd2,
    MODE_FLAT     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_HOLD,
    FS_MUL
  } front_state_t;

  // input request payload, last field in the lowest bits
  typedef struct packed {
    logic [3:0]        spare;
    logic [31:0]       inv_scale;
    logic [31:0]       texture_mid;
    logic [ROW_W-1:0]  bottom_row;
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  column;
    logic [DATA_W-1:0] table_value;
    logic [DATA_W-1:0] table_index;
  } in_item_t;

  // result payload, last field in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] pixel_color;
    logic [ADDR_W-1:0] pixel_address;
  } out_item_t;

  // classified draw passed from front to back
  typedef struct packed {
    logic              textured;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  top_row;
    logic [ROW_W-1:0]  bottom_row;
    logic [WALK_W-1:0] walk;
    logic [WALK_W-1:0] step;
    logic [DATA_W-1:0] color;
  } draw_cmd_t;

  // table load port driven by the front
  typedef struct packed {
    logic              color_we;
    logic [CT_AW-1:0]  color_addr;
    logic              texel_we;
    logic [TEX_AW-1:0] texel_addr;
    logic [DATA_W-1:0] data;
  } tbl_wr_t;

endpackage

// ===== design/tcr_ram.sv =====
// generic single-write, single-read ram with registered read data
module tcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tcr_front.sv =====
// front end: takes requests, performs table loads, prepares draw commands
`include "textured_column_rasterizer_macros.svh"
module tcr_front
  import tcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  mode_t        in_mode,
  input  in_item_t     in_item,
  input  logic [7:0]   center_row,
  input  logic         drained,
  output tbl_wr_t      wr,
  output logic         cmd_valid,
  input  logic         cmd_ready,
  output draw_cmd_t    cmd
);

  front_state_t      state_r, state_nxt;
  mode_t             mode_r;
  in_item_t          item_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  logic [ROW_W-1:0]  bot_sat;
  logic              empty_col;
  logic [DIFF_W-1:0] diff;
  logic [31:0]       diff_ext;
  logic [31:0]       prod_full;
  logic [PROD_W-1:0] start;

  // clamp bottom to the view and spot empty columns
  always_comb begin
    if ({1'b0, item_r.bottom_row} > 7'(VIEW_HEIGHT - 1)) begin
      bot_sat = ROW_W'(VIEW_HEIGHT - 1);
    end else begin
      bot_sat = item_r.bottom_row;
    end
    empty_col = bot_sat < item_r.top_row;
  end

  // texture offset: (top - center) * inv_scale, low bits only
  assign diff      = DIFF_W'({3'b000, item_r.top_row}) - DIFF_W'({1'b0, center_row});
  assign diff_ext  = {{(32 - DIFF_W){diff[DIFF_W-1]}}, diff};
  assign prod_full = diff_ext * item_r.inv_scale;
  assign start     = item_r.texture_mid[PROD_W-1:0] + prod_r;

  // draw command from the held request
  always_comb begin
    cmd.textured   = (mode_r == MODE_TEXTURED);
    cmd.column     = item_r.column;
    cmd.top_row    = item_r.top_row;
    cmd.bottom_row = bot_sat;
    cmd.walk       = start[PROD_W-1 -: WALK_W];
    cmd.step       = item_r.inv_scale[PROD_W-1 -: WALK_W];
    cmd.color      = item_r.table_value;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // held request and product
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_mode;
      item_r <= in_item;
    end
    prod_r <= prod_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    prod_nxt      = prod_r;
    in_tready     = 1'b0;
    cmd_valid     = 1'b0;
    wr.color_we   = 1'b0;
    wr.color_addr = item_r.table_index;
    wr.texel_we   = 1'b0;
    wr.texel_addr = item_r.table_index[TEX_AW-1:0];
    wr.data       = item_r.table_value;
    unique case (state_r)
      FS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = FS_HOLD;
        end
      end
      FS_HOLD: begin
        unique case (mode_r)
          MODE_TABLE: begin
            // loads wait until no earlier draw still reads the tables
            if (drained) begin
              wr.color_we = 1'b1;
              state_nxt   = FS_IDLE;
            end
          end
          MODE_TEXEL: begin
            if (drained) begin
              wr.texel_we = (item_r.table_index < 8'(TEX_DEPTH));
              state_nxt   = FS_IDLE;
            end
          end
          MODE_TEXTURED, MODE_FLAT: begin
            if (empty_col) begin
              state_nxt = FS_IDLE;
            end else begin
              prod_nxt  = prod_full[PROD_W-1:0];
              state_nxt = FS_MUL;
            end
          end
          default: state_nxt = FS_IDLE;
        endcase
      end
      FS_MUL: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  `TCR_ASSERT_IMP(a_load_when_drained, wr.color_we || wr.texel_we, drained)

endmodule

// ===== design/tcr_cmd_queue.sv =====
// two-entry queue of draw commands between front and back
`include "textured_column_rasterizer_macros.svh"
module tcr_cmd_queue
  import tcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  draw_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output draw_cmd_t pop_cmd,
  output logic      empty
);

  draw_cmd_t           slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                push, pop;

  assign push_ready = count_r != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign empty      = count_r == '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `TCR_ASSERT_IMP(a_q_ptrs_empty, count_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

// ===== design/tcr_back.sv =====
// back end: walks the rows of a draw and looks up texel and color per pixel
`include "textured_column_rasterizer_macros.svh"
module tcr_back
  import tcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  draw_cmd_t             cmd,
  output logic                  tex_re,
  output logic [TEX_AW-1:0]     tex_addr,
  input  logic [DATA_W-1:0]     tex_q,
  output logic                  color_re,
  output logic [CT_AW-1:0]      color_addr,
  input  logic [DATA_W-1:0]     color_q,
  output logic                  idle,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output out_item_t             out_item,
  output logic                  out_tlast
);

  logic              busy_r;
  draw_cmd_t         cmd_r;
  logic [ROW_W-1:0]  row_r;

  logic              s1_valid_r, s1_last_r, s1_textured_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_color_r;
  logic              s2_valid_r, s2_last_r, s2_textured_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [DATA_W-1:0] s2_color_r;

  logic              out_valid_r, out_last_r;
  out_item_t         out_item_r;

  logic              adv, issue, row_last;
  logic [ADDR_W-1:0] pix_addr;

  // whole pipeline moves when the output register is free or drained
  assign adv       = !out_valid_r || out_tready;
  assign issue     = busy_r && adv;
  assign row_last  = row_r == cmd_r.bottom_row;
  assign cmd_ready = !busy_r;
  assign idle      = !busy_r && !s1_valid_r && !s2_valid_r;
  assign pix_addr  = ADDR_W'(32'(row_r) * SCREEN_WIDTH)
                   + ADDR_W'(32'(cmd_r.column) << COLUMN_SHIFT);

  // ram reads: texel from the walk, then color from the texel
  assign tex_re     = adv;
  assign tex_addr   = cmd_r.walk[WALK_W-1 -: TEX_AW];
  assign color_re   = adv;
  assign color_addr = tex_q;

  // row sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (!busy_r) begin
      busy_r <= cmd_valid;
    end else if (issue && row_last) begin
      busy_r <= 1'b0;
    end
  end

  // row sequencer data
  always_ff @(posedge clk) begin
    if (!busy_r && cmd_valid) begin
      cmd_r <= cmd;
      row_r <= cmd.top_row;
    end else if (issue) begin
      row_r      <= row_r + 1'b1;
      cmd_r.walk <= cmd_r.walk + cmd_r.step;
    end
  end

  // stage valids and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r                <= pix_addr;
      s1_last_r                <= row_last;
      s1_textured_r            <= cmd_r.textured;
      s1_color_r               <= cmd_r.color;
      s2_addr_r                <= s1_addr_r;
      s2_last_r                <= s1_last_r;
      s2_textured_r            <= s1_textured_r;
      s2_color_r               <= s1_color_r;
      out_item_r.pixel_address <= s2_addr_r;
      out_item_r.pixel_color   <= s2_textured_r ? color_q : s2_color_r;
      out_last_r               <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_item   = out_item_r;
  assign out_tlast  = out_last_r;

  `TCR_ASSERT_IMP(a_row_in_range, busy_r, row_r <= cmd_r.bottom_row)
  `TCR_ASSERT_NXT(a_last_row_ends, issue && row_last, !busy_r)

endmodule

// ===== design/textured_column_rasterizer.sv =====
// top level of the textured column rasterizer
//
// in_* carries requests: mode in in_tuser selects a color table load, a
// texel load, a textured column or a flat column. out_* carries one pixel
// per drawn row, top to bottom, with out_tlast on the column's last pixel.
// cfg_we/cfg_wdata set the horizon center row; write it only while idle.
//
// the front holds one request at a time: it captures it, does the
// offset multiply, then hands the draw to a 2-entry queue; a load or
// an empty column goes back to idle without a hand-off. loads wait
// until all queued and running draws have finished their table reads.
// the back emits one pixel per cycle while out_tready is high once a
// draw is running; it takes the next draw from the queue only after it
// has issued the last row of the current one.
// the back walks rows through a 3-stage chain (texel ram read, color ram
// read, output register); a low out_tready freezes the whole chain and the
// queue and front fill up behind it without loss.
// reset (rst_n low, synchronous) empties the queue and pipeline and sets
// the center row to 32; the table contents stay undefined until loaded.
module textured_column_rasterizer
  import tcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode[1:0]
  input  logic [1:0]            in_tuser,
  // table_index[7:0], table_value[15:8], column[23:16], top_row[29:24],
  // bottom_row[35:30], texture_mid[67:36], inv_scale[99:68], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_address[15:0], pixel_color[23:16]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);

  logic [7:0]        center_r;
  tbl_wr_t           wr;
  logic              f_cmd_valid, f_cmd_ready;
  draw_cmd_t         f_cmd;
  logic              b_cmd_valid, b_cmd_ready;
  draw_cmd_t         b_cmd;
  logic              q_empty, back_idle;
  logic              tex_re, color_re;
  logic [TEX_AW-1:0] tex_addr;
  logic [CT_AW-1:0]  color_addr;
  logic [DATA_W-1:0] tex_q, color_q;
  out_item_t         out_item;

  // center row register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RESET;
    end else if (cfg_we) begin
      center_r <= cfg_wdata;
    end
  end

  tcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (mode_t'(in_tuser)),
    .in_item    (in_item_t'(in_tdata)),
    .center_row (center_r),
    .drained    (q_empty && back_idle),
    .wr         (wr),
    .cmd_valid  (f_cmd_valid),
    .cmd_ready  (f_cmd_ready),
    .cmd        (f_cmd)
  );

  tcr_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_cmd_valid),
    .push_ready (f_cmd_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_cmd_valid),
    .pop_ready  (b_cmd_ready),
    .pop_cmd    (b_cmd),
    .empty      (q_empty)
  );

  tcr_ram #(.WIDTH(DATA_W), .DEPTH(TEX_DEPTH)) u_texel_ram (
    .clk   (clk),
    .we    (wr.texel_we),
    .waddr (wr.texel_addr),
    .wdata (wr.data),
    .re    (tex_re),
    .raddr (tex_addr),
    .rdata (tex_q)
  );

  tcr_ram #(.WIDTH(DATA_W), .DEPTH(CT_DEPTH)) u_color_ram (
    .clk   (clk),
    .we    (wr.color_we),
    .waddr (wr.color_addr),
    .wdata (wr.data),
    .re    (color_re),
    .raddr (color_addr),
    .rdata (color_q)
  );

  tcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (b_cmd_valid),
    .cmd_ready  (b_cmd_ready),
    .cmd        (b_cmd),
    .tex_re     (tex_re),
    .tex_addr   (tex_addr),
    .tex_q      (tex_q),
    .color_re   (color_re),
    .color_addr (color_addr),
    .color_q    (color_q),
    .idle       (back_idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = out_item;

endmodule

// ===== bench/textured_column_rasterizer_tb.sv =====
// testbench for the textured column rasterizer: self-checking stream test with its own predictor
`timescale 1ns / 100ps

module textured_column_rasterizer_tb;
  import tcr_pkg::*;

  // one expected pixel of a drawn column
  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] color;
    logic              last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // mode[1:0]
  logic [1:0]            in_tuser = MODE_TABLE;
  // table_index, table_value, column, top_row, bottom_row, texture_mid, inv_scale, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pixel_address[15:0], pixel_color[23:16]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [7:0]            cfg_wdata = '0;

  // predictor state: tables, which entries were loaded, horizon row
  logic [DATA_W-1:0] palette_lut [CT_DEPTH];
  logic [DATA_W-1:0] texel_col [TEX_DEPTH];
  bit                color_known [CT_DEPTH];
  bit                texel_known [TEX_DEPTH];
  logic [7:0]        center_row = CENTER_RESET;

  pixel_t    pixels_due [$];
  pixel_t    pixel_want;
  out_item_t pixel_seen;
  int        mismatches = 0;
  int        requests_taken = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  textured_column_rasterizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(string what);
    if (mismatches < 30) $display("mismatch: %s", what);
    mismatches++;
  endtask

  // texture walk at the top row: bits 22:7 of mid + (top - center) * scale
  function automatic logic [WALK_W-1:0] walk_origin(in_item_t d);
    logic [31:0] offset;
    offset = d.texture_mid + (32'(d.top_row) - 32'(center_row)) * d.inv_scale;
    return offset[WALK_SHIFT +: WALK_W];
  endfunction

  // update tables or queue the pixels that one accepted request draws
  function automatic void rasterize_request(mode_t m, in_item_t d);
    pixel_t            px;
    logic [WALK_W-1:0] walk;
    int                last_row;
    case (m)
      MODE_TABLE: begin
        palette_lut[d.table_index] = d.table_value;
        color_known[d.table_index] = 1'b1;
      end
      MODE_TEXEL: begin
        if (d.table_index < TEX_DEPTH) begin
          texel_col[d.table_index[TEX_AW-1:0]] = d.table_value;
          texel_known[d.table_index[TEX_AW-1:0]] = 1'b1;
        end
      end
      default: begin
        walk = walk_origin(d);
        last_row = (d.bottom_row > VIEW_HEIGHT - 1) ? VIEW_HEIGHT - 1 : int'(d.bottom_row);
        for (int row = d.top_row; row <= last_row; row++) begin
          px.address = ADDR_W'(row * SCREEN_WIDTH + (int'(d.column) << COLUMN_SHIFT));
          px.color = (m == MODE_TEXTURED) ?
                     palette_lut[texel_col[walk[WALK_W-1:TEXEL_SHIFT]]] : d.table_value;
          px.last = (row == last_row);
          pixels_due.push_back(px);
          walk = walk + d.inv_scale[WALK_SHIFT +: WALK_W];
        end
      end
    endcase
  endfunction

  // offer one request, hold it until taken, then predict it
  task automatic send_request(mode_t m, in_item_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    if (!(m == MODE_TEXEL && d.table_index >= TEX_DEPTH)) requests_taken++;
    rasterize_request(m, d);
  endtask

  task automatic send_load(mode_t m, logic [7:0] idx, logic [7:0] val);
    in_item_t d;
    d = '0;
    d.table_index = idx;
    d.table_value = val;
    d.column = 8'($urandom);
    d.top_row = 6'($urandom);
    d.bottom_row = 6'($urandom);
    d.texture_mid = $urandom;
    d.inv_scale = $urandom;
    send_request(m, d);
  endtask

  // textured draws first load any texel or palette entry they would read
  task automatic send_draw(mode_t m, logic [7:0] col, logic [5:0] top, logic [5:0] bot,
                           logic [31:0] mid, logic [31:0] scale, logic [7:0] fill);
    in_item_t          d;
    logic [WALK_W-1:0] walk;
    logic [TEX_AW-1:0] slot;
    d = '0;
    d.table_index = 8'($urandom);
    d.table_value = fill;
    d.column = col;
    d.top_row = top;
    d.bottom_row = bot;
    d.texture_mid = mid;
    d.inv_scale = scale;
    if (m == MODE_TEXTURED) begin
      walk = walk_origin(d);
      for (int row = top; row <= int'(bot); row++) begin
        slot = walk[WALK_W-1:TEXEL_SHIFT];
        if (!texel_known[slot]) send_load(MODE_TEXEL, {1'b0, slot}, 8'($urandom));
        if (!color_known[texel_col[slot]]) send_load(MODE_TABLE, texel_col[slot], 8'($urandom));
        walk = walk + scale[WALK_SHIFT +: WALK_W];
      end
    end
    send_request(m, d);
  endtask

  // hold off the sender until every pixel has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_due.size() != 0);
  endtask

  // register write only while idle, after the pipeline has settled
  task automatic set_center(logic [7:0] value);
    wait_drained();
    repeat (24) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    center_row = value;
  endtask

  // palette and texel loads at the index extremes, ignored texel loads
  task automatic test_table_loads();
    send_load(MODE_TEXEL, 8'd0, 8'hFF);
    send_load(MODE_TEXEL, 8'd127, 8'h00);
    send_load(MODE_TABLE, 8'd255, 8'h00);
    send_load(MODE_TABLE, 8'd0, 8'hFF);
    send_load(MODE_TEXEL, 8'd128, 8'h33);
    send_load(MODE_TEXEL, 8'd255, 8'hCC);
    // walks pinned on texel 0 and texel 127
    send_draw(MODE_TEXTURED, 8'd1, 6'd0, 6'd3, 32'h0000_0000, 32'h0000_0000, 8'($urandom));
    send_draw(MODE_TEXTURED, 8'd2, 6'd4, 6'd6, 32'h007F_0000, 32'h0000_0000, 8'($urandom));
  endtask

  task automatic test_flat_columns();
    send_draw(MODE_FLAT, 8'd255, 6'd0, 6'd63, $urandom, $urandom, 8'hFF);
    send_draw(MODE_FLAT, 8'd0, 6'd63, 6'd63, $urandom, $urandom, 8'h00);
    send_draw(MODE_FLAT, 8'($urandom), 6'd5, 6'd6, $urandom, $urandom, 8'($urandom));
  endtask

  // bottom above top: nothing drawn
  task automatic test_empty_columns();
    send_draw(MODE_TEXTURED, 8'($urandom), 6'd40, 6'd39, $urandom, $urandom, 8'($urandom));
    send_draw(MODE_FLAT, 8'($urandom), 6'd63, 6'd0, $urandom, $urandom, 8'($urandom));
  endtask

  // step extremes of the texture walk
  task automatic test_textured_columns();
    send_draw(MODE_TEXTURED, 8'd255, 6'd0, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 8'($urandom));
    send_draw(MODE_TEXTURED, 8'd0, 6'd0, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 8'($urandom));
    send_draw(MODE_TEXTURED, 8'($urandom), 6'd20, 6'd31, $urandom, 32'h0001_0000,
              8'($urandom));
    send_draw(MODE_TEXTURED, 8'($urandom), 6'd63, 6'd63, $urandom, 32'hFFFF_0000,
              8'($urandom));
  endtask

  // mostly draws with random content, some loads, empty columns and pauses
  task automatic test_random_traffic(int count, int sender_idle, int receiver_stall);
    int          target;
    int          pick;
    logic [5:0]  top;
    logic [5:0]  bot;
    logic [31:0] scale;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    target = requests_taken + count;
    while (requests_taken < target) begin
      pick = $urandom_range(99);
      top = 6'($urandom_range(63));
      case ($urandom_range(9))
        0: bot = 6'($urandom_range(63));
        1, 2, 3, 4, 5: bot = (int'(top) + 7 > 63) ? 6'd63 : top + 6'($urandom_range(7));
        default: bot = 6'($urandom_range(63, top));
      endcase
      scale = $urandom_range(32'h3FFFF);
      if ($urandom_range(1)) scale = -scale;
      if ($urandom_range(9) < 3) scale = $urandom;
      if (pick < 8) send_load(MODE_TABLE, 8'($urandom), 8'($urandom));
      else if (pick < 14) send_load(MODE_TEXEL, 8'($urandom), 8'($urandom));
      else if (pick < 16) wait_drained();
      else if (pick < 60)
        send_draw(MODE_TEXTURED, 8'($urandom), top, bot, $urandom, scale, 8'($urandom));
      else send_draw(MODE_FLAT, 8'($urandom), top, bot, $urandom, $urandom, 8'($urandom));
    end
  endtask

  // result check against the oldest expected pixel, then next stall decision
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pixel_seen = out_tdata;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel at address %0h", pixel_seen.pixel_address));
      end else begin
        pixel_want = pixels_due.pop_front();
        if (pixel_seen.pixel_address !== pixel_want.address)
          report_mismatch($sformatf("address %0h, expected %0h",
                                    pixel_seen.pixel_address, pixel_want.address));
        if (pixel_seen.pixel_color !== pixel_want.color)
          report_mismatch($sformatf("color %0h at %0h, expected %0h", pixel_seen.pixel_color,
                                    pixel_want.address, pixel_want.color));
        if (out_tlast !== pixel_want.last)
          report_mismatch($sformatf("last %b at %0h, expected %b", out_tlast,
                                    pixel_want.address, pixel_want.last));
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_loads();
    test_flat_columns();
    test_empty_columns();
    set_center(8'd0);
    test_textured_columns();
    set_center(8'd255);
    test_textured_columns();
    set_center(8'($urandom));
    test_random_traffic(43, 0, 0);
    set_center(8'd0);
    test_random_traffic(43, 57, 0);
    set_center(8'($urandom));
    test_random_traffic(43, 0, 57);
    set_center(CENTER_RESET);
    test_random_traffic(43, 25, 25);
    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== textured_column_rasterizer.f =====
+incdir+design
design/tcr_pkg.sv
design/tcr_ram.sv
design/tcr_front.sv
design/tcr_cmd_queue.sv
design/tcr_back.sv
design/textured_column_rasterizer.sv
bench/textured_column_rasterizer_tb.sv
